// ===== sv/gpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the cursor step block.
// No dependencies; every other file refers to it by scoped names.
package gpc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT       = 24;

  // Datapath widths: CORDIC registers, multiplier operands, accumulator.
  localparam int CW = 42;
  localparam int VW = 40;
  localparam int BW = 26;
  localparam int AW = 68;

  localparam logic [1:0] CMD_FWD   = 2'd0;
  localparam logic [1:0] CMD_BACK  = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;
  localparam logic [1:0] CMD_LEFT  = 2'd3;

  localparam logic [1:0] REG_POLAR = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_TURN  = 2'd2;

  localparam logic signed [BW-1:0] INV_GAIN_Q24 = 26'sd10188014;
  localparam logic signed [31:0]   INV_GAIN_Q30 = 32'sd652032874;
  localparam logic [31:0]          HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0]          QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [VW-1:0] ON_PLAYER    = 40'sd65;

  typedef struct packed {
    logic                 en;
    logic                 clr;
    logic signed [VW-1:0] a;
    logic signed [BW-1:0] b;
  } mac_op_t;

  typedef struct packed {
    logic                 start;
    logic                 rot;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          t;
  } cor_req_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/gpc_mac.sv =====
`timescale 1ns / 1ps
// Shared signed multiply-accumulate unit, one product per cycle.
// Depends on gpc_pkg.
module gpc_mac (
  input  logic                          clk,
  input  gpc_pkg::mac_op_t              op,
  output logic signed [gpc_pkg::AW-1:0] acc
);

  logic signed [gpc_pkg::VW+gpc_pkg::BW-1:0] prod;

  assign prod = $signed(op.a) * $signed(op.b);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= (op.clr ? '0 : acc) + gpc_pkg::AW'(prod);
    end
  end

endmodule

// ===== sv/gpc_cordic.sv =====
`timescale 1ns / 1ps
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on gpc_pkg.
module gpc_cordic #(
  parameter int STEPS = gpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gpc_pkg::cor_req_t             req,
  output logic                          busy,
  output logic                          done,
  output logic signed [gpc_pkg::CW-1:0] x_out,
  output logic signed [gpc_pkg::CW-1:0] y_out,
  output logic [31:0]                   ang_out
);

  localparam int ITERS = (STEPS < gpc_pkg::ATAN_COUNT) ? STEPS : gpc_pkg::ATAN_COUNT;
  localparam int CNTW  = $clog2(ITERS);
  localparam logic [CNTW-1:0] LAST = CNTW'(ITERS - 1);

  logic signed [gpc_pkg::CW-1:0] x, y, dx, dy;
  logic signed [33:0]            z, at;
  logic [CNTW-1:0]               cnt;
  logic                          rot, dn;
  logic [31:0]                   tf, t2;

  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    at = signed'({2'b00, gpc_pkg::atan_lut(5'(cnt))});
    // down: x -= dx, y += dy, z -= atan
    dn = rot ? !z[33] : !(!y[gpc_pkg::CW-1] && (y != '0));
    tf = req.t + gpc_pkg::QUARTER_TURN;
    t2 = tf[31] ? req.t + gpc_pkg::HALF_TURN : req.t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rot  <= req.rot;
        if (req.rot) begin
          x <= tf[31] ? -gpc_pkg::CW'(gpc_pkg::INV_GAIN_Q30)
                      : gpc_pkg::CW'(gpc_pkg::INV_GAIN_Q30);
          y <= '0;
          z <= signed'({{2{t2[31]}}, t2});
        end else if (req.x[gpc_pkg::VW-1]) begin
          x <= -gpc_pkg::CW'(req.x);
          y <= -gpc_pkg::CW'(req.y);
          z <= signed'({2'b00, gpc_pkg::HALF_TURN});
        end else begin
          x <= gpc_pkg::CW'(req.x);
          y <= gpc_pkg::CW'(req.y);
          z <= '0;
        end
      end else if (busy) begin
        if (dn) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign x_out   = x;
  assign y_out   = y;
  assign ang_out = z[31:0];

endmodule

// ===== sv/grid_polar_cursor_step.sv =====
`timescale 1ns / 1ps
// Top level of the cursor step block: sequencer around one CORDIC and one MAC.
// Depends on gpc_pkg, gpc_mac and gpc_cordic.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------
//   in      | in_valid / in_ready   | cmd, player_*, cursor_*, up_*, right_*
//   out     | out_valid / out_ready | new_x, new_z
//   cfg     | cfg_we                | cfg_addr, cfg_data
//
// One beat at a time. Grid mode runs up to two CORDIC passes, polar mode up to five.
// Synchronous reset clears the sequencer, output valid and the heading.
// A stalled output holds the sequencer in its final state; in_ready is high
// only while idle.
module grid_polar_cursor_step #(
  parameter int CORDIC_STEPS = gpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] player_x,
  input  logic signed [31:0] player_z,
  input  logic signed [31:0] cursor_x,
  input  logic signed [31:0] cursor_z,
  input  logic signed [15:0] up_x,
  input  logic signed [15:0] up_z,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [23:0]        cfg_data
);

  localparam int VW = gpc_pkg::VW;
  localparam int BW = gpc_pkg::BW;
  localparam int AW = gpc_pkg::AW;
  localparam int CW = gpc_pkg::CW;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_GX   = 5'd1;
  localparam logic [4:0] S_GZ   = 5'd2;
  localparam logic [4:0] S_GE   = 5'd3;
  localparam logic [4:0] S_P0   = 5'd4;
  localparam logic [4:0] S_P1   = 5'd5;
  localparam logic [4:0] S_P2   = 5'd6;
  localparam logic [4:0] S_P3   = 5'd7;
  localparam logic [4:0] S_P4   = 5'd8;
  localparam logic [4:0] S_PV   = 5'd9;
  localparam logic [4:0] S_P6   = 5'd10;
  localparam logic [4:0] S_H1   = 5'd11;
  localparam logic [4:0] S_H2   = 5'd12;
  localparam logic [4:0] S_H3   = 5'd13;
  localparam logic [4:0] S_H4   = 5'd14;
  localparam logic [4:0] S_HW   = 5'd15;
  localparam logic [4:0] S_CM   = 5'd16;
  localparam logic [4:0] S_RW   = 5'd17;
  localparam logic [4:0] S_D1   = 5'd18;
  localparam logic [4:0] S_D2   = 5'd19;
  localparam logic [4:0] S_D3   = 5'd20;
  localparam logic [4:0] S_D4   = 5'd21;
  localparam logic [4:0] S_D5   = 5'd22;
  localparam logic [4:0] S_D6   = 5'd23;
  localparam logic [4:0] S_R0   = 5'd24;
  localparam logic [4:0] S_RV   = 5'd25;
  localparam logic [4:0] S_RM   = 5'd26;
  localparam logic [4:0] S_RR   = 5'd27;
  localparam logic [4:0] S_RF   = 5'd28;

  // configuration
  logic        polar;
  logic [23:0] step;
  logic [15:0] turn;

  // sequencer and item registers
  logic [4:0]           state;
  logic [1:0]           cmd_r;
  logic signed [31:0]   px, pz, cx, cz, nx, nz, cc, ss;
  logic signed [15:0]   ux, uz, rx, rz, hx, hz;
  logic signed [32:0]   vx, vz;
  logic signed [VW-1:0] f, tv, radius;
  logic [31:0]          theta;
  logic signed [BW-1:0] ddx, ddz;

  // shared units
  gpc_pkg::mac_op_t     mop;
  gpc_pkg::cor_req_t    creq;
  logic signed [AW-1:0] acc;
  logic                 cor_busy, cor_done;
  logic signed [CW-1:0] cor_x, cor_y;
  logic [31:0]          cor_ang;

  // helpers
  logic signed [16:0]   gdx, gdz;
  logic signed [AW-1:0] acc_s14, acc_s22, acc_s24;
  logic signed [VW-1:0] dist_raw, step_v, dist_next;
  logic [31:0]          turn32, theta_next;

  gpc_mac u_mac (
    .clk (clk),
    .op  (mop),
    .acc (acc)
  );

  gpc_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (creq),
    .busy    (cor_busy),
    .done    (cor_done),
    .x_out   (cor_x),
    .y_out   (cor_y),
    .ang_out (cor_ang)
  );

  assign in_ready = (state == S_IDLE);
  assign acc_s14  = acc >>> 14;
  assign acc_s22  = acc >>> 22;
  assign acc_s24  = acc >>> 24;
  assign dist_raw = VW'(acc_s24);
  assign step_v   = VW'(step);
  assign turn32   = {turn, 16'h0000};

  // grid step direction and the polar command applied to distance and angle
  always_comb begin
    unique case (cmd_r)
      gpc_pkg::CMD_FWD:   begin gdx = 17'(ux);  gdz = 17'(uz);  end
      gpc_pkg::CMD_BACK:  begin gdx = -17'(ux); gdz = -17'(uz); end
      gpc_pkg::CMD_RIGHT: begin gdx = 17'(rx);  gdz = 17'(rz);  end
      default:            begin gdx = -17'(rx); gdz = -17'(rz); end
    endcase
    dist_next  = radius;
    theta_next = theta;
    unique case (cmd_r)
      gpc_pkg::CMD_FWD:   dist_next  = radius + step_v;
      gpc_pkg::CMD_BACK:  dist_next  = (radius > step_v) ? radius - step_v : '0;
      gpc_pkg::CMD_RIGHT: theta_next = theta + turn32;
      default:            theta_next = theta - turn32;
    endcase
  end

  // issue to the MAC and CORDIC per state
  always_comb begin
    mop  = '0;
    creq = '0;
    unique case (state)
      S_GX: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = VW'(gdx);
                  mop.b = BW'(step); end
      S_GZ: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = VW'(gdz);
                  mop.b = BW'(step); end
      S_P0: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = VW'(vx); mop.b = BW'(ux); end
      S_P1: begin mop.en = 1'b1; mop.a = VW'(vz); mop.b = BW'(uz); end
      S_P2: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = VW'(vx); mop.b = BW'(rx); end
      S_P3: begin mop.en = 1'b1; mop.a = VW'(vz); mop.b = BW'(rz); end
      S_P4: begin creq.start = 1'b1; creq.x = f; creq.y = VW'(acc_s14); end
      S_PV: begin mop.en = cor_done; mop.clr = 1'b1; mop.a = VW'(cor_x);
                  mop.b = gpc_pkg::INV_GAIN_Q24; end
      S_P6: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = VW'(hx); mop.b = BW'(ux); end
      S_H1: begin mop.en = 1'b1; mop.a = VW'(hz); mop.b = BW'(uz); end
      S_H2: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = VW'(hx); mop.b = BW'(rx); end
      S_H3: begin mop.en = 1'b1; mop.a = VW'(hz); mop.b = BW'(rz); end
      S_H4: begin creq.start = 1'b1; creq.x = tv; creq.y = VW'(acc); end
      S_CM: begin creq.start = 1'b1; creq.rot = 1'b1; creq.t = theta_next; end
      S_RW: begin mop.en = cor_done; mop.clr = 1'b1;
                  mop.a = VW'($signed(cor_x[31:0])); mop.b = BW'(ux); end
      S_D1: begin mop.en = 1'b1; mop.a = VW'(ss); mop.b = BW'(rx); end
      S_D2: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = VW'(cc); mop.b = BW'(uz); end
      S_D3: begin mop.en = 1'b1; mop.a = VW'(ss); mop.b = BW'(rz); end
      S_D4: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = radius; mop.b = ddx; end
      S_D5: begin mop.en = 1'b1; mop.clr = 1'b1; mop.a = radius; mop.b = ddz; end
      S_R0: begin creq.start = 1'b1; creq.x = VW'(nx) - VW'(px);
                  creq.y = VW'(nz) - VW'(pz); end
      S_RV: begin mop.en = cor_done; mop.clr = 1'b1; mop.a = VW'(cor_x);
                  mop.b = gpc_pkg::INV_GAIN_Q24; end
      S_RM: begin creq.start = (dist_raw > gpc_pkg::ON_PLAYER); creq.rot = 1'b1;
                  creq.t = cor_ang; end
      default: begin end
    endcase
  end

  // configuration writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      polar <= 1'b0;
      step  <= 24'd65536;
      turn  <= 16'd2731;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gpc_pkg::REG_POLAR: polar <= cfg_data[0];
        gpc_pkg::REG_STEP:  step  <= cfg_data;
        gpc_pkg::REG_TURN:  turn  <= cfg_data[15:0];
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hx        <= '0;
      hz        <= '0;
    end else begin
      // drop valid once the beat is taken, unless a new beat replaces it
      if (out_valid && out_ready && state != S_RF) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            px <= player_x; pz <= player_z;
            cx <= cursor_x; cz <= cursor_z;
            ux <= up_x; uz <= up_z; rx <= right_x; rz <= right_z;
            vx <= 33'(cursor_x) - 33'(player_x);
            vz <= 33'(cursor_z) - 33'(player_z);
            state <= polar ? S_P0 : S_GX;
          end
        end
        S_GX: state <= S_GZ;
        S_GZ: begin
          nx    <= gpc_pkg::sat32(48'(cx) + 48'(acc_s14));
          state <= S_GE;
        end
        S_GE: begin
          nz    <= gpc_pkg::sat32(48'(cz) + 48'(acc_s14));
          state <= S_R0;
        end
        S_P0: state <= S_P1;
        S_P1: state <= S_P2;
        S_P2: begin
          f     <= VW'(acc_s14);
          state <= S_P3;
        end
        S_P3: state <= S_P4;
        S_P4: state <= S_PV;
        S_PV: begin
          if (cor_done) begin
            theta <= cor_ang;
            state <= S_P6;
          end
        end
        S_P6: begin
          // cursor on the player: fall back to the stored heading
          if (dist_raw <= gpc_pkg::ON_PLAYER) begin
            radius <= '0;
            theta  <= '0;
            state  <= (hx != '0 || hz != '0) ? S_H1 : S_CM;
          end else begin
            radius <= dist_raw;
            state  <= S_CM;
          end
        end
        S_H1: state <= S_H2;
        S_H2: begin
          tv    <= VW'(acc);
          state <= S_H3;
        end
        S_H3: state <= S_H4;
        S_H4: state <= S_HW;
        S_HW: begin
          if (cor_done) begin
            theta <= cor_ang;
            state <= S_CM;
          end
        end
        S_CM: begin
          radius <= dist_next;
          theta  <= theta_next;
          state  <= S_RW;
        end
        S_RW: begin
          if (cor_done) begin
            cc    <= cor_x[31:0];
            ss    <= cor_y[31:0];
            state <= S_D1;
          end
        end
        S_D1: state <= S_D2;
        S_D2: begin
          ddx   <= BW'(acc_s22);
          state <= S_D3;
        end
        S_D3: state <= S_D4;
        S_D4: begin
          ddz   <= BW'(acc_s22);
          state <= S_D5;
        end
        S_D5: begin
          nx    <= gpc_pkg::sat32(48'(px) + 48'(acc_s22));
          state <= S_D6;
        end
        S_D6: begin
          nz    <= gpc_pkg::sat32(48'(pz) + 48'(acc_s22));
          state <= S_R0;
        end
        S_R0: state <= S_RV;
        S_RV: begin
          if (cor_done) begin
            state <= S_RM;
          end
        end
        S_RM: state <= (dist_raw > gpc_pkg::ON_PLAYER) ? S_RR : S_RF;
        S_RR: begin
          if (cor_done) begin
            hx    <= gpc_pkg::clamp16(24'(cor_x >>> 16));
            hz    <= gpc_pkg::clamp16(24'(cor_y >>> 16));
            state <= S_RF;
          end
        end
        S_RF: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            if (polar && radius == '0) begin
              hx <= gpc_pkg::clamp16(24'(ddx >>> 8));
              hz <= gpc_pkg::clamp16(24'(ddz >>> 8));
            end
            new_x     <= nx;
            new_z     <= nz;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_cordic_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cor_busy)
    else $error("CORDIC busy while sequencer idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted beat did not start the sequencer");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == S_PV || state == S_HW || state == S_RW ||
                  state == S_RV || state == S_RR))
    else $error("CORDIC finished outside a wait state");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for grid_polar_cursor_step: directed table, then random phases.
// Depends on gpc_pkg (command and register codes) and the block's RTL.
module tb;

  localparam int STEPS = 16;
  localparam int ON_PLAYER_LSB = 65;
  localparam int SETTLE = 150;      // longest polar pass plus margin
  localparam int LIMIT = 2000000;
  localparam logic [1:0] REG_NONE = 2'd3;   // unused index, must be ignored

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] px, pz, cx, cz;
    logic signed [15:0] ux, uz, rx, rz;
  } press_t;

  typedef struct {
    bit                 pol;
    press_t             p;
    bit                 chk;
    logic signed [31:0] ex, ez;
  } row_t;

  typedef struct {
    logic signed [31:0] x, z;
  } pos_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         cmd = gpc_pkg::CMD_FWD;
  logic signed [31:0] player_x = 0, player_z = 0, cursor_x = 0, cursor_z = 0;
  logic signed [15:0] up_x = 0, up_z = 0, right_x = 0, right_z = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] new_x, new_z;
  logic               cfg_we = 0;
  logic [1:0]         cfg_addr = gpc_pkg::REG_POLAR;
  logic [23:0]        cfg_data = 0;

  grid_polar_cursor_step uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Mirror of the block's configuration and heading, the queue of predictions and the counters.
  bit           polar_q;
  longint       step_q, turn_q;
  longint       head_x, head_z;
  pos_t         pending_pos[$];
  pos_t         last_pos;
  int           mismatches = 0;
  int unsigned  cycles = 0;

  const bit [31:0] atan_rom [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Vectoring pass: gain-corrected magnitude and binary angle of (x, y).
  function automatic void vec_polar(input longint x_in, y_in, output longint mag,
                                    output bit [31:0] ang);
    longint x, y, dx, dy;
    x = x_in;
    y = y_in;
    ang = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += atan_rom[i];
      end else begin
        x -= dx; y += dy; ang -= atan_rom[i];
      end
    end
    mag = (x * 64'sd10188014) >>> 24;
  endfunction

  // Rotation pass: cosine and sine in Q1.30.
  function automatic void rot_cos_sin(input bit [31:0] t_in, output longint c,
                                      output longint s);
    bit [31:0] t;
    longint z, dx, dy;
    t = t_in;
    c = 64'sd652032874;
    s = 0;
    if (((t + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      c = -c;
      t += 32'h8000_0000;
    end
    z = longint'(signed'(t));
    for (int i = 0; i < STEPS; i++) begin
      dx = s >>> i;
      dy = c >>> i;
      if (z >= 0) begin
        c -= dx; s += dy; z -= longint'(atan_rom[i]);
      end else begin
        c += dx; s -= dy; z += longint'(atan_rom[i]);
      end
    end
  endfunction

  function automatic void update_heading(input longint nx, nz, px, pz);
    longint mag, c, s;
    bit [31:0] ang;
    vec_polar(nx - px, nz - pz, mag, ang);
    if (mag > ON_PLAYER_LSB) begin
      rot_cos_sin(ang, c, s);
      head_x = clip16(c >>> 16);
      head_z = clip16(s >>> 16);
    end
  endfunction

  // Work out the new cursor position for one key press; advance the heading.
  function automatic pos_t predict_cursor(input press_t p);
    longint px, pz, cx, cz, ux, uz, rx, rz, dx, dz, nx, nz;
    longint vx, vz, f, r, radius, c, s, ddx, ddz, unused;
    bit [31:0] theta, turn;
    pos_t res;
    px = p.px; pz = p.pz; cx = p.cx; cz = p.cz;
    ux = p.ux; uz = p.uz; rx = p.rx; rz = p.rz;
    if (!polar_q) begin
      case (p.cmd)
        gpc_pkg::CMD_FWD:   begin dx = ux;  dz = uz;  end
        gpc_pkg::CMD_BACK:  begin dx = -ux; dz = -uz; end
        gpc_pkg::CMD_RIGHT: begin dx = rx;  dz = rz;  end
        default:            begin dx = -rx; dz = -rz; end
      endcase
      nx = sat_q16(cx + ((dx * step_q) >>> 14));
      nz = sat_q16(cz + ((dz * step_q) >>> 14));
      update_heading(nx, nz, px, pz);
    end else begin
      vx = cx - px;
      vz = cz - pz;
      f = (vx * ux + vz * uz) >>> 14;
      r = (vx * rx + vz * rz) >>> 14;
      turn = 32'(turn_q << 16);
      vec_polar(f, r, radius, theta);
      if (radius <= ON_PLAYER_LSB) begin
        radius = 0;
        theta = 0;
        if (head_x != 0 || head_z != 0)
          vec_polar(head_x * ux + head_z * uz, head_x * rx + head_z * rz, unused, theta);
      end
      case (p.cmd)
        gpc_pkg::CMD_FWD:   radius += step_q;
        gpc_pkg::CMD_BACK:  radius = (radius > step_q) ? radius - step_q : 0;
        gpc_pkg::CMD_RIGHT: theta += turn;
        default:            theta -= turn;
      endcase
      rot_cos_sin(theta, c, s);
      ddx = (c * ux + s * rx) >>> 22;
      ddz = (c * uz + s * rz) >>> 22;
      nx = sat_q16(px + ((radius * ddx) >>> 22));
      nz = sat_q16(pz + ((radius * ddz) >>> 22));
      update_heading(nx, nz, px, pz);
      if (radius == 0) begin
        head_x = clip16(ddx >>> 8);
        head_z = clip16(ddz >>> 8);
      end
    end
    res.x = nx[31:0];
    res.z = nz[31:0];
    return res;
  endfunction

  // Present one key press, hold it until accepted, then queue its prediction.
  task automatic send_press(input press_t p);
    in_valid <= 1;
    cmd <= p.cmd;
    player_x <= p.px; player_z <= p.pz;
    cursor_x <= p.cx; cursor_z <= p.cz;
    up_x <= p.ux; up_z <= p.uz; right_x <= p.rx; right_z <= p.rz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_pos = predict_cursor(p);
    pending_pos.push_back(last_pos);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      gpc_pkg::REG_POLAR: polar_q = val[0];
      gpc_pkg::REG_STEP:  step_q = val;
      gpc_pkg::REG_TURN:  turn_q = val[15:0];
      default: ;
    endcase
  endtask

  // Drop valid, wait out every pending beat and let the sequencer settle.
  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input bit pol, input longint stp, input longint trn);
    drain();
    write_reg(gpc_pkg::REG_POLAR, {23'd0, pol});
    write_reg(gpc_pkg::REG_STEP, stp[23:0]);
    write_reg(gpc_pkg::REG_TURN, trn[23:0]);
    write_reg(REG_NONE, 24'($urandom()));
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis;
    return 16'($urandom_range(0, 32768)) - 16'sd16384;
  endfunction

  // Random key press: mostly a chain that follows the previous cursor.
  function automatic press_t rand_press(input press_t prev);
    press_t p;
    int sel;
    p = prev;
    p.cmd = 2'($urandom_range(0, 3));
    sel = $urandom_range(0, 99);
    if (sel < 10 || sel >= 90) begin
      if ($urandom_range(0, 4) == 0) begin
        p.px = $urandom(); p.pz = $urandom();
      end else begin
        p.px = 32'($urandom_range(0, 1 << 24)) - 32'sd8388608;
        p.pz = 32'($urandom_range(0, 1 << 24)) - 32'sd8388608;
      end
      p.ux = rand_axis();
      p.uz = rand_axis();
      case ($urandom_range(0, 3))
        0: begin p.rx = p.uz;  p.rz = -p.ux; end
        1: begin p.rx = -p.uz; p.rz = p.ux;  end
        2: begin p.rx = rand_axis(); p.rz = rand_axis(); end
        default: begin
          p.ux = 0; p.uz = 16'sd16384; p.rx = 16'sd16384; p.rz = 0;
        end
      endcase
    end
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      p.cx = last_pos.x; p.cz = last_pos.z;
    end else if (sel < 70) begin
      p.cx = p.px; p.cz = p.pz;
    end else if (sel < 85) begin
      // near the on-player threshold
      p.cx = p.px + 32'($urandom_range(0, 200)) - 32'sd100;
      p.cz = p.pz + 32'($urandom_range(0, 200)) - 32'sd100;
    end else begin
      p.cx = $urandom(); p.cz = $urandom();
    end
    return p;
  endfunction

  // Receiver: the stall pattern switches between always ready, random and mostly stalled.
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    pos_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: x=%0d z=%0d", new_x, new_z);
      end else begin
        want = pending_pos.pop_front();
        if (new_x !== want.x || new_z !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d z=%0d, got x=%0d z=%0d",
                     want.x, want.z, new_x, new_z);
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t rows[$];

  task automatic add_row(input bit pol, input logic [1:0] c, input logic signed [31:0] px, pz,
                         cx, cz, input logic signed [15:0] ux, uz, rx, rz, input bit chk,
                         input logic signed [31:0] ex, ez);
    row_t r;
    r.pol = pol; r.p.cmd = c;
    r.p.px = px; r.p.pz = pz; r.p.cx = cx; r.p.cz = cz;
    r.p.ux = ux; r.p.uz = uz; r.p.rx = rx; r.p.rz = rz;
    r.chk = chk; r.ex = ex; r.ez = ez;
    rows.push_back(r);
  endtask

  initial begin
    press_t prev;
    pos_t got;
    int burst, gap, phase_items;
    longint stp, trn;
    bit pol;

    polar_q = 0; step_q = 65536; turn_q = 2731;
    head_x = 0; head_z = 0;
    last_pos = '{0, 0};

    // Grid rows at reset settings: values read straight off the step rule.
    add_row(0, gpc_pkg::CMD_FWD,   0, 0, 0, 0, 0, 16384, 16384, 0, 1, 0, 65536);
    add_row(0, gpc_pkg::CMD_BACK,  0, 0, 0, 0, 0, 16384, 16384, 0, 1, 0, -65536);
    add_row(0, gpc_pkg::CMD_RIGHT, 0, 0, 0, 0, 0, 16384, 16384, 0, 1, 65536, 0);
    add_row(0, gpc_pkg::CMD_LEFT,  0, 0, 0, 0, 0, 16384, 16384, 0, 1, -65536, 0);
    add_row(0, gpc_pkg::CMD_FWD, 0, 0, 32'sh7fff_ffff, 0, 16384, 0, 0, 16384, 1,
            32'sh7fff_ffff, 0);
    add_row(0, gpc_pkg::CMD_BACK, 0, 0, 32'sh8000_0000, 0, 16384, 0, 0, 16384, 1,
            32'sh8000_0000, 0);
    add_row(0, gpc_pkg::CMD_FWD, 0, 0, 0, 0, -16384, -16384, -16384, 16384, 1,
            -65536, -65536);
    add_row(0, gpc_pkg::CMD_RIGHT, 5, 5, 12345, -7, 0, 0, 0, 0, 1, 12345, -7);
    add_row(0, gpc_pkg::CMD_LEFT, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
            32'sh8000_0000, 16384, -16384, -16384, 16384, 0, 0, 0);
    // Polar rows, checked by the predictor.
    add_row(1, gpc_pkg::CMD_FWD,   0, 0, 0, 0, 0, 16384, 16384, 0, 0, 0, 0);  // on player
    add_row(1, gpc_pkg::CMD_RIGHT, 0, 0, 65536, 0, 0, 16384, 16384, 0, 0, 0, 0);
    add_row(1, gpc_pkg::CMD_LEFT,  100, 200, 100, 300000, 0, 16384, 16384, 0, 0, 0, 0);
    add_row(1, gpc_pkg::CMD_BACK,  0, 0, 65536, 65536, 11585, 11585, 11585, -11585,
            0, 0, 0);
    add_row(1, gpc_pkg::CMD_BACK,  0, 0, 30, 30, 0, 16384, 16384, 0, 0, 0, 0);  // to zero
    add_row(1, gpc_pkg::CMD_RIGHT, 7, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0);  // zero frame
    add_row(1, gpc_pkg::CMD_FWD,   7, 7, 7, 7, 0, 16384, 16384, 0, 0, 0, 0);
    add_row(1, gpc_pkg::CMD_FWD, 32'sh7fff_0000, 0, 32'sh7fff_ff00, 0, 16384, 0, 0, 16384,
            0, 0, 0);
    add_row(1, gpc_pkg::CMD_LEFT, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff,
            -16384, 16384, 16384, -16384, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].pol != polar_q) configure(rows[i].pol, step_q, turn_q);
      send_press(rows[i].p);
      got = last_pos;
      if (rows[i].chk && (got.x !== rows[i].ex || got.z !== rows[i].ez)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected x=%0d z=%0d, predicted x=%0d z=%0d",
                   i, rows[i].ex, rows[i].ez, got.x, got.z);
      end
      prev = rows[i].p;
    end

    // Random phases; the first few pin the register extremes.
    for (int ph = 0; ph < 8; ph++) begin
      pol = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      case (ph)
        0: begin stp = 0;        trn = 0;     end
        1: begin stp = 8388608;  trn = 32768; end
        2: begin stp = 8388608;  trn = 0;     end
        3: begin stp = 0;        trn = 32768; end
        default: begin
          stp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388608)
                                            : $urandom_range(1, 1 << 19);
          trn = $urandom_range(0, 32768);
        end
      endcase
      configure(pol, stp, trn);
      phase_items = 0;
      while (phase_items < 100) begin
        burst = $urandom_range(1, 12);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        for (int k = 0; k < burst; k++) begin
          prev = rand_press(prev);
          send_press(prev);
          phase_items++;
        end
        if (gap != 0) begin
          in_valid <= 0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
